[sv/ihh_pkg.sv]
// ----------------------------------------------------------------------------
// ihh_pkg
// shared widths, codes and types of the height hold controller
// ----------------------------------------------------------------------------
package ihh_pkg;

   localparam int ECHO_W     = 14;
   localparam int BYTE_W     = 8;
   localparam int DIST_W     = 9;
   localparam int TARGET_W   = 9;
   localparam int GAIN_W     = 12;
   localparam int LOWER_W    = 8;
   localparam int LEVEL_W    = 15;
   localparam int DUTY_W     = 8;
   localparam int CMD_W      = 3;
   localparam int ERR_W      = 10;
   localparam int FRAC_W     = 8;
   localparam int ACC_W      = LEVEL_W + FRAC_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 9'd30;
   localparam logic [TARGET_W-1:0] TARGET_MAX   = 9'd511;
   localparam logic [DUTY_W-1:0]   DUTY_MAX     = 8'd255;

   localparam logic [BYTE_W-1:0]   FRAME_END  = 8'h3B;
   localparam logic [15:0]         CODE_UP    = 16'h7570;
   localparam logic [15:0]         CODE_DOWN  = 16'h776E;
   localparam logic [15:0]         CODE_LEFT  = 16'h6674;
   localparam logic [15:0]         CODE_RIGHT = 16'h6874;

   localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BAD   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_LIMIT = 3'd4;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_prop;
      logic [GAIN_W-1:0]  gain_integ;
      logic [GAIN_W-1:0]  gain_deriv;
      logic [LOWER_W-1:0] lower_limit;
      logic [LEVEL_W-1:0] upper_limit;
   } cfg_type;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] rx_byte;
      logic [DIST_W-1:0] dist_cm;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [DIST_W-1:0]  dist_cm;
   } pid_out_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [CMD_W-1:0]    cmd;
   } frm_out_type;

endpackage

[sv/ihh_dist.sv]
// ----------------------------------------------------------------------------
// ihh_dist
// echo time to distance, truncating divide by a constant via reciprocal
// ----------------------------------------------------------------------------
module ihh_dist
   import ihh_pkg::*;
#(
   parameter int US_PER_CM = 57
) (
   input  logic [ECHO_W-1:0] echo_us,
   output logic [DIST_W-1:0] dist_cm
);

   // rounded-up reciprocal with ECHO_W + log2 bits of precision is exact for all echoes
   localparam int LOG_D   = $clog2(US_PER_CM);
   localparam int SHIFT   = ECHO_W + LOG_D;
   localparam int RECIP_W = ECHO_W + 2;
   localparam int PROD_W  = ECHO_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(US_PER_CM) - 64'd1) / 64'(US_PER_CM));

   logic [PROD_W-1:0] prod;

   assign prod    = PROD_W'(echo_us) * PROD_W'(RECIP);
   assign dist_cm = prod[SHIFT +: DIST_W];

endmodule

[sv/ihh_framer.sv]
// ----------------------------------------------------------------------------
// ihh_framer
// command frame assembly and setpoint up/down
// ----------------------------------------------------------------------------
module ihh_framer
   import ihh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [BYTE_W-1:0] rx_byte,
   output frm_out_type       frm_out
);

   logic [1:0]          count_ff, count_in;
   logic [BYTE_W-1:0]   first_ff, first_in;
   logic [BYTE_W-1:0]   second_ff, second_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [CMD_W-1:0]    cmd;
   logic [15:0]         code;

   assign code = {first_ff, second_ff};

   always_comb begin
      count_in  = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      target_in = target_ff;
      cmd       = CMD_NONE;
      if (fire) begin
         if (rx_byte != FRAME_END) begin
            unique case (count_ff)
               2'd0: begin
                  first_in = rx_byte;
                  count_in = 2'd1;
               end
               2'd1: begin
                  second_in = rx_byte;
                  count_in  = 2'd2;
               end
               default: count_in = 2'd3;
            endcase
         end else begin
            count_in = 2'd0;
            if (count_ff != 2'd2) begin
               cmd = CMD_BAD;
            end else begin
               priority if (code == CODE_UP) begin
                  cmd = CMD_UP;
                  if (target_ff != TARGET_MAX) target_in = target_ff + 1'b1;
               end else if (code == CODE_DOWN) begin
                  cmd = CMD_DOWN;
                  if (target_ff != '0) target_in = target_ff - 1'b1;
               end else if (code == CODE_LEFT) begin
                  cmd = CMD_LEFT;
               end else if (code == CODE_RIGHT) begin
                  cmd = CMD_RIGHT;
               end else begin
                  cmd = CMD_BAD;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         first_ff  <= '0;
         second_ff <= '0;
         target_ff <= TARGET_RESET;
      end else begin
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         target_ff <= target_in;
      end
   end

   assign frm_out.target = target_in;
   assign frm_out.cmd    = cmd;

endmodule

[sv/ihh_pid.sv]
// ----------------------------------------------------------------------------
// ihh_pid
// velocity-form pid update of the q15.8 drive accumulator
// ----------------------------------------------------------------------------
module ihh_pid
   import ihh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [DIST_W-1:0]   dist_cm,
   input  logic [TARGET_W-1:0] target_cm,
   input  cfg_type             cfg,
   output pid_out_type         pid_out
);

   localparam int D1_W  = ERR_W + 1;
   localparam int D2_W  = ERR_W + 2;
   localparam int G_W   = GAIN_W + 1;
   localparam int SUM_W = ACC_W + 3;

   logic signed [ERR_W-1:0] err_last_ff, err_before_ff, e0;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;

   logic signed [D1_W-1:0]       d1;
   logic signed [D2_W-1:0]       d2;
   logic signed [G_W-1:0]        g_prop, g_integ, g_deriv;
   logic signed [G_W+D1_W-1:0]   p_prop;
   logic signed [G_W+ERR_W-1:0]  p_integ;
   logic signed [G_W+D2_W-1:0]   p_deriv;
   logic signed [SUM_W-1:0]      incr, acc_sum, lo, hi, raised, clamped;

   assign e0 = $signed({1'b0, target_cm}) - $signed({1'b0, dist_cm});
   assign d1 = D1_W'(e0) - D1_W'(err_last_ff);
   assign d2 = D2_W'(e0) - (D2_W'(err_last_ff) <<< 1) + D2_W'(err_before_ff);

   assign g_prop  = $signed({1'b0, cfg.gain_prop});
   assign g_integ = $signed({1'b0, cfg.gain_integ});
   assign g_deriv = $signed({1'b0, cfg.gain_deriv});

   // errors are integers and gains q4.8, so each product is already q.8
   assign p_prop  = g_prop * d1;
   assign p_integ = g_integ * e0;
   assign p_deriv = g_deriv * d2;

   assign incr    = SUM_W'(p_prop) + SUM_W'(p_integ) + SUM_W'(p_deriv);
   assign acc_sum = $signed({3'b000, acc_ff}) + incr;
   assign lo      = $signed({(SUM_W-LOWER_W-FRAC_W)'(0), cfg.lower_limit, FRAC_W'(0)});
   assign hi      = $signed({3'b000, cfg.upper_limit, FRAC_W'(0)});

   // floor first, then ceiling: upper limit wins when they cross
   assign raised  = (acc_sum < lo) ? lo : acc_sum;
   assign clamped = (raised > hi) ? hi : raised;

   assign acc_in  = fire ? clamped[ACC_W-1:0] : acc_ff;
   assign dist_in = fire ? dist_cm : dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_last_ff   <= '0;
         err_before_ff <= '0;
         acc_ff        <= '0;
         dist_ff       <= '0;
      end else begin
         acc_ff  <= acc_in;
         dist_ff <= dist_in;
         if (fire) begin
            err_before_ff <= err_last_ff;
            err_last_ff   <= e0;
         end
      end
   end

   assign pid_out.level   = acc_in[ACC_W-1:FRAC_W];
   assign pid_out.dist_cm = dist_in;

endmodule

[sv/incremental_pid_height_hold.sv]
// ----------------------------------------------------------------------------
// incremental_pid_height_hold
// distance hold controller: echo samples drive a velocity-form pid, serial
// command frames nudge the setpoint
//
// Every beat on req_ gives exactly one beat on rsp_. The block takes one beat
// per clock while the result register is not stalled, and the result beat is
// offered from the result register: the echo time is turned into centimetres
// on the way into the input register, then the pid update (three gain
// multiplies, accumulate, clamp) and the command framer run combinationally
// into the result register. That combinational state update is what sets the
// rate, since each sample's accumulator and error history feed the next item.
// req_ready drops only while the input register is full and the result
// register is stalled. csr_ writes are always taken and should only be issued
// while no beat is in flight; indexes past upper_limit are ignored.
// ----------------------------------------------------------------------------
module incremental_pid_height_hold
   import ihh_pkg::*;
#(
   parameter int US_PER_CM = 57
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic [ECHO_W-1:0]     req_echo_us,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DUTY_W-1:0]     rsp_pwm_duty,
   output logic [LEVEL_W-1:0]    rsp_drive_level,
   output logic [TARGET_W-1:0]   rsp_setpoint_cm,
   output logic [DIST_W-1:0]     rsp_distance_cm,
   output logic [CMD_W-1:0]      rsp_command_seen,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;

   // input stage
   item_type          item_ff, item_in;
   logic              in_vld_ff;
   logic [DIST_W-1:0] req_dist;

   // result stage
   logic               rsp_vld_ff;
   logic [DUTY_W-1:0]  duty_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [TARGET_W-1:0] setpoint_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [CMD_W-1:0]   cmd_ff;

   logic        out_free, fire, sample_fire, byte_fire;
   pid_out_type pid_out;
   frm_out_type frm_out;

   // config write port, never back-pressures
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop   <= 12'd256;
         cfg_ff.gain_integ  <= 12'd256;
         cfg_ff.gain_deriv  <= 12'd77;
         cfg_ff.lower_limit <= 8'd110;
         cfg_ff.upper_limit <= 15'd32767;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GAIN_PROP:   cfg_ff.gain_prop   <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_INTEG:  cfg_ff.gain_integ  <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_DERIV:  cfg_ff.gain_deriv  <= csr_wdata[GAIN_W-1:0];
            REG_LOWER_LIMIT: cfg_ff.lower_limit <= csr_wdata[LOWER_W-1:0];
            REG_UPPER_LIMIT: cfg_ff.upper_limit <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: result register frees as it is taken, input register as it moves on
   assign out_free    = !rsp_vld_ff || rsp_ready;
   assign fire        = in_vld_ff && out_free;
   assign req_ready   = !in_vld_ff || out_free;
   assign sample_fire = fire && item_ff.op;
   assign byte_fire   = fire && !item_ff.op;

   // distance only depends on the echo, so it is worked out ahead of the state
   ihh_dist #(
      .US_PER_CM (US_PER_CM)
   ) u_dist (
      .echo_us (req_echo_us),
      .dist_cm (req_dist)
   );

   assign item_in.op      = req_op;
   assign item_in.rx_byte = req_rx_byte;
   assign item_in.dist_cm = req_dist;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   ihh_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .fire    (byte_fire),
      .rx_byte (item_ff.rx_byte),
      .frm_out (frm_out)
   );

   ihh_pid u_pid (
      .clock     (clock),
      .reset     (reset),
      .fire      (sample_fire),
      .dist_cm   (item_ff.dist_cm),
      .target_cm (frm_out.target),
      .cfg       (cfg_ff),
      .pid_out   (pid_out)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         duty_ff     <= (pid_out.level > LEVEL_W'(DUTY_MAX)) ? DUTY_MAX
                                                             : pid_out.level[DUTY_W-1:0];
         level_ff    <= pid_out.level;
         setpoint_ff <= frm_out.target;
         dist_ff     <= pid_out.dist_cm;
         cmd_ff      <= frm_out.cmd;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_pwm_duty     = duty_ff;
   assign rsp_drive_level  = level_ff;
   assign rsp_setpoint_cm  = setpoint_ff;
   assign rsp_distance_cm  = dist_ff;
   assign rsp_command_seen = cmd_ff;

`ifndef NO_ASSERTIONS
   // a sample beat never reports a command
   a_sample_no_cmd: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> rsp_command_seen == CMD_NONE)
      else $error("command reported for a sample beat");

   // a sample beat leaves the setpoint alone
   a_sample_keeps_setpoint: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> rsp_setpoint_cm == $past(frm_out.target))
      else $error("setpoint moved on a sample beat");

   // the accumulator never passes the ceiling in force at the update
   a_level_ceiling: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> rsp_drive_level <= $past(cfg_ff.upper_limit))
      else $error("drive level above upper limit");

   // back-pressure only when both registers are full and the output is stalled
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && rsp_vld_ff && !rsp_ready))
      else $error("input stalled with room in the pipeline");
`endif

endmodule
